### rtl/ict_pkg.sv
// Shared types and constants for the in-order completion table.
// Used by ict_ctrl, ict_datapath and in_order_completion_table_top.
package ict_pkg;

  localparam int TABLE_ENTRIES = 16;
  localparam int DATA_BITS     = 64;
  localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  // Operation codes
  localparam logic [1:0] OP_OPEN    = 2'd0;
  localparam logic [1:0] OP_FILL    = 2'd1;
  localparam logic [1:0] OP_DROP    = 2'd2;
  localparam logic [1:0] OP_RELEASE = 2'd3;

  // Status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_EXISTS    = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] frame_id;
    logic        is_reprocess;
    logic [63:0] data_in;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        released;
    logic [31:0] frame_out;
    logic [63:0] data_out;
  } out_t;

  // Controller to datapath
  typedef struct packed {
    logic load;    // latch request, restart scan
    logic step;    // examine one entry
    logic commit;  // update table, load result register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic scan_last;
  } stat_t;

endpackage

### rtl/ict_ctrl.sv
// Sequencer for the completion table: accept, scan, commit.
// Depends on ict_pkg for command and status structs.
module ict_ctrl
  import ict_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  output logic  out_valid,
  input  logic  out_ready,
  output cmd_t  cmd,
  input  stat_t stat
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_t;

  state_t state;

  // Commands decoded from state
  always_comb begin
    in_ready   = (state == S_IDLE);
    cmd.load   = (state == S_IDLE) && in_valid;
    cmd.step   = (state == S_SCAN);
    cmd.commit = (state == S_FINISH) && (!out_valid || out_ready);
  end

  // State and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) state <= S_SCAN;
        end
        S_SCAN: begin
          if (stat.scan_last) state <= S_FINISH;
        end
        S_FINISH: begin
          if (cmd.commit) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### rtl/ict_datapath.sv
// Entry storage, one-entry-per-cycle scan and result register.
// Depends on ict_pkg for types, op/status codes and table sizes.
module ict_datapath
  import ict_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  in_t   in_data,
  input  cmd_t  cmd,
  output stat_t stat,
  output out_t  out_data
);

  // Table storage
  logic [TABLE_ENTRIES-1:0] entry_valid;
  logic [TABLE_ENTRIES-1:0] entry_reprocess;
  logic [TABLE_ENTRIES-1:0] entry_ready;
  logic [31:0]              entry_frame [TABLE_ENTRIES];
  logic [DATA_BITS-1:0]     entry_data  [TABLE_ENTRIES];

  // Latched request
  logic [1:0]           req_op;
  logic [31:0]          req_frame;
  logic                 req_cls;
  logic [DATA_BITS-1:0] req_data;

  // Scan state
  logic [IDX_W-1:0]     scan_idx;
  logic                 hit_found;
  logic [IDX_W-1:0]     hit_idx;
  logic                 hit_ready;
  logic                 free_found;
  logic [IDX_W-1:0]     free_idx;
  logic                 nh_found;     // normal head
  logic [IDX_W-1:0]     nh_idx;
  logic [31:0]          nh_frame;
  logic                 nh_ready;
  logic [DATA_BITS-1:0] nh_data;
  logic                 rh_found;     // reprocess head
  logic [IDX_W-1:0]     rh_idx;
  logic [31:0]          rh_frame;
  logic                 rh_ready;
  logic [DATA_BITS-1:0] rh_data;

  // Current entry under scan
  logic                 cur_valid;
  logic                 cur_cls;
  logic                 cur_ready;
  logic [31:0]          cur_frame;
  logic [DATA_BITS-1:0] cur_data;
  logic                 cur_hit;

  // Commit decisions
  logic [1:0]           res_status;
  logic                 res_rel;
  logic [31:0]          res_frame;
  logic [DATA_BITS-1:0] res_data;
  logic                 set_en;
  logic                 clr_en;
  logic [IDX_W-1:0]     clr_idx;
  logic                 fill_en;

  assign stat.scan_last = (scan_idx == IDX_W'(TABLE_ENTRIES - 1));

  always_comb begin
    cur_valid = entry_valid[scan_idx];
    cur_cls   = entry_reprocess[scan_idx];
    cur_ready = entry_ready[scan_idx];
    cur_frame = entry_frame[scan_idx];
    cur_data  = entry_data[scan_idx];
    cur_hit   = cur_valid && (cur_frame == req_frame);
  end

  // Request latch and scan trackers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_op     <= in_data.operation;
      req_frame  <= in_data.frame_id;
      req_cls    <= in_data.is_reprocess;
      req_data   <= in_data.data_in[DATA_BITS-1:0];
      scan_idx   <= '0;
      hit_found  <= 1'b0;
      free_found <= 1'b0;
      nh_found   <= 1'b0;
      rh_found   <= 1'b0;
    end else if (cmd.step) begin
      scan_idx <= scan_idx + 1'b1;
      if (cur_hit) begin
        hit_found <= 1'b1;
        hit_idx   <= scan_idx;
        hit_ready <= cur_ready;
      end
      if (!cur_valid && !free_found) begin
        free_found <= 1'b1;
        free_idx   <= scan_idx;
      end
      if (cur_valid && !cur_cls && (!nh_found || cur_frame < nh_frame)) begin
        nh_found <= 1'b1;
        nh_idx   <= scan_idx;
        nh_frame <= cur_frame;
        nh_ready <= cur_ready;
        nh_data  <= cur_data;
      end
      if (cur_valid && cur_cls && (!rh_found || cur_frame < rh_frame)) begin
        rh_found <= 1'b1;
        rh_idx   <= scan_idx;
        rh_frame <= cur_frame;
        rh_ready <= cur_ready;
        rh_data  <= cur_data;
      end
    end
  end

  // Result and table update decision
  always_comb begin
    res_status = ST_OK;
    res_rel    = 1'b0;
    res_frame  = '0;
    res_data   = '0;
    set_en     = 1'b0;
    clr_en     = 1'b0;
    clr_idx    = hit_idx;
    fill_en    = 1'b0;
    case (req_op)
      OP_OPEN: begin
        if (hit_found) res_status = ST_EXISTS;
        else if (!free_found) res_status = ST_FULL;
        else set_en = 1'b1;
      end
      OP_FILL: begin
        if (!hit_found) res_status = ST_NOT_FOUND;
        else if (hit_ready) res_status = ST_EXISTS;
        else fill_en = 1'b1;
      end
      OP_DROP: begin
        clr_en = hit_found;
      end
      OP_RELEASE: begin
        if (nh_found && nh_ready) begin
          res_rel   = 1'b1;
          res_frame = nh_frame;
          res_data  = nh_data;
          clr_en    = 1'b1;
          clr_idx   = nh_idx;
        end else if (rh_found && rh_ready) begin
          res_rel   = 1'b1;
          res_frame = rh_frame;
          res_data  = rh_data;
          clr_en    = 1'b1;
          clr_idx   = rh_idx;
        end else begin
          res_status = ST_NOT_FOUND;
        end
      end
      default: res_status = ST_OK;
    endcase
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
    end else if (cmd.commit) begin
      if (set_en) entry_valid[free_idx] <= 1'b1;
      if (clr_en) entry_valid[clr_idx] <= 1'b0;
    end
  end

  // Entry contents
  always_ff @(posedge clk) begin
    if (cmd.commit && set_en) begin
      entry_reprocess[free_idx] <= req_cls;
      entry_ready[free_idx]     <= 1'b0;
      entry_frame[free_idx]     <= req_frame;
    end
    if (cmd.commit && fill_en) begin
      entry_ready[hit_idx] <= 1'b1;
      entry_data[hit_idx]  <= req_data;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_data.status    <= res_status;
      out_data.released  <= res_rel;
      out_data.frame_out <= res_frame;
      out_data.data_out  <= 64'(res_data);
    end
  end

endmodule

### rtl/in_order_completion_table_top.sv
// In-order completion table: top level joining controller and datapath.
// Depends on ict_pkg, ict_ctrl and ict_datapath.
//
// Usage:
//   Requests arrive on in_valid/in_ready with an in_t beat (open, fill,
//   drop or release). Every request gives exactly one out_t beat on
//   out_valid/out_ready carrying status and, for release, the frame
//   number and payload handed out.
//   Sequence: each request is taken while the controller is idle, then the
//   datapath examines one table entry per cycle over all TABLE_ENTRIES
//   entries (16 as built), then a commit updates the table and loads the
//   result register. A new request is taken only once the previous one has
//   committed; the single-entry scan over the table sets the request rate.
//   Stalls: the result register holds its beat until out_ready. A new
//   request is still taken and scanned meanwhile; its commit waits until
//   the result register is free.
//   Reset (rst, synchronous) empties the table and drops any pending
//   result; no clearing pass is needed.
module in_order_completion_table_top
  import ict_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  cmd_t  cmd;
  stat_t stat;

  ict_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  ict_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .in_data  (in_data),
    .cmd      (cmd),
    .stat     (stat),
    .out_data (out_data)
  );

endmodule
